// ===== rtl/core/fbwm_pkg.sv =====
package fbwm_pkg;

    // Fixed field widths
    localparam int WORD_W    = 16;
    localparam int CODE_W    = 2;
    localparam int LEN_W     = 3;
    localparam int CODES_W   = 64;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int FEATURES_DEF    = 8;
    localparam int MAX_PATTERN_DEF = 4;

    localparam logic [CODE_W-1:0] CODE_WILDCARD = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CODES  = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 3'd1;

    localparam logic MODE_CONTIGUOUS  = 1'b0;
    localparam logic MODE_SUBSEQUENCE = 1'b1;

    // Broadcast from the top to every cell
    typedef struct packed {
        logic             step;      // input beat accepted
        logic             clear;     // beat was the last of its word
        logic [LEN_W-1:0] len;       // pattern length in use, saturated
        logic [LEN_W-1:0] progress;  // greedy subsequence progress
    } cell_ctl_t;

    // Per-cell status back to the top
    typedef struct packed {
        logic advance;    // this cell holds the subsequence cursor and fits
        logic found_now;  // full contiguous occurrence ends at this beat
    } cell_stat_t;

endpackage

// ===== rtl/core/fbwm_cell.sv =====
module fbwm_cell #(
    parameter int FEATURES = fbwm_pkg::FEATURES_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbwm_pkg::cell_ctl_t           ctl,
    input  logic [fbwm_pkg::CODES_W-1:0]  pattern_codes,
    input  logic [fbwm_pkg::WORD_W-1:0]   word_bundle,
    input  logic                          prev_hit,
    output logic                          hit,
    output fbwm_pkg::cell_stat_t          stat
);

    logic [FEATURES-1:0] feat_ok;
    logic                fits;
    logic                in_use;
    logic                hit_reg;
    logic                hit_next;

    for (genvar j = 0; j < FEATURES; j++) begin : g_feat
        localparam int POS = CELL_IDX * FEATURES + j;
        if (2 * POS >= fbwm_pkg::CODES_W) begin : g_beyond
            // pattern bits past the register read as wildcard
            assign feat_ok[j] = 1'b1;
        end else begin : g_in
            logic [fbwm_pkg::CODE_W-1:0] pcode;
            logic [fbwm_pkg::CODE_W-1:0] wcode;
            assign pcode = pattern_codes[2*POS +: fbwm_pkg::CODE_W];
            if (2 * j >= fbwm_pkg::WORD_W) begin : g_wzero
                assign wcode = '0;
            end else begin : g_wbits
                assign wcode = word_bundle[2*j +: fbwm_pkg::CODE_W];
            end
            assign feat_ok[j] = (pcode == fbwm_pkg::CODE_WILDCARD) || (pcode == wcode);
        end
    end

    assign fits     = &feat_ok;
    assign in_use   = 32'(ctl.len) > 32'(CELL_IDX);
    assign hit_next = in_use && prev_hit && fits;

    assign stat.advance   = in_use && fits && (32'(ctl.progress) == 32'(CELL_IDX));
    assign stat.found_now = hit_next && (32'(ctl.len) == 32'(CELL_IDX + 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.step) begin
            hit_reg <= ctl.clear ? 1'b0 : hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/core/feature_bundle_wildcard_matcher.sv =====
// Wildcard pattern matcher over a stream of feature bundles.
// Input channel (s_): one bundle of 2-bit feature codes per beat; s_last_bundle
// closes the word. Result channel (m_): one beat per word, m_matched set when
// the configured pattern occurs in it (contiguous or gapped, per match_mode).
// Config channel (cfg_): index 0 pattern_length, 1 match_mode, 2 pattern_codes;
// always ready, write only while no word is in flight.
// Throughput: one bundle per cycle while s_ready is high. A row of MAX_PATTERN
// cells each compares one pattern bundle against the incoming bundle and passes
// its prefix hit to the next cell, so every bundle is absorbed in the cycle it
// is accepted. The result is registered in the cycle after the last beat.
// Reset: synchronous, active low; registers return to length 1, contiguous
// mode, all-zero pattern, and match state is cleared.
// Stall: the result register holds until taken; s_ready drops while a result
// is pending and m_ready is low, so the input channel pauses, mid-word beats
// included, until the waiting result is taken.
module feature_bundle_wildcard_matcher #(
    parameter int FEATURES    = fbwm_pkg::FEATURES_DEF,
    parameter int MAX_PATTERN = fbwm_pkg::MAX_PATTERN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fbwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbwm_pkg::CODES_W-1:0]    cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fbwm_pkg::WORD_W-1:0]     s_word_bundle,
    input  logic                            s_last_bundle,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_matched
);

    localparam int LEN_MAX_CODE = (1 << fbwm_pkg::LEN_W) - 1;
    localparam int MAX_LEN      = (MAX_PATTERN < LEN_MAX_CODE) ? MAX_PATTERN : LEN_MAX_CODE;

    logic [fbwm_pkg::LEN_W-1:0]   len_reg;
    logic                         mode_reg;
    logic [fbwm_pkg::CODES_W-1:0] codes_reg;

    logic [fbwm_pkg::LEN_W-1:0]   progress_reg;
    logic [fbwm_pkg::LEN_W-1:0]   progress_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         m_valid_reg;
    logic                         m_matched_reg;
    logic                         matched_next;

    logic [fbwm_pkg::LEN_W-1:0]   len_used;
    logic                         s_fire;
    logic                         last_fire;

    fbwm_pkg::cell_ctl_t          ctl;
    fbwm_pkg::cell_stat_t [MAX_PATTERN-1:0] stat;
    logic [MAX_PATTERN-1:0]       hit_vec;
    logic [MAX_PATTERN-1:0]       adv_vec;
    logic [MAX_PATTERN-1:0]       found_vec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign last_fire = s_fire && s_last_bundle;

    assign len_used = (len_reg > fbwm_pkg::LEN_W'(MAX_LEN)) ?
                      fbwm_pkg::LEN_W'(MAX_LEN) : len_reg;

    assign ctl.step     = s_fire;
    assign ctl.clear    = s_last_bundle;
    assign ctl.len      = len_used;
    assign ctl.progress = progress_reg;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic prev_hit;
        if (i == 0) begin : g_head
            assign prev_hit = 1'b1;
        end else begin : g_link
            assign prev_hit = hit_vec[i-1];
        end

        fbwm_cell #(
            .FEATURES (FEATURES),
            .CELL_IDX (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (ctl),
            .pattern_codes (codes_reg),
            .word_bundle   (s_word_bundle),
            .prev_hit      (prev_hit),
            .hit           (hit_vec[i]),
            .stat          (stat[i])
        );

        assign adv_vec[i]   = stat[i].advance;
        assign found_vec[i] = stat[i].found_now;
    end

    // at most one cell holds the cursor, so OR is the increment
    assign progress_next = progress_reg + fbwm_pkg::LEN_W'(|adv_vec);
    assign found_next    = found_reg || (|found_vec);

    always_comb begin
        if (len_used == '0) begin
            matched_next = 1'b0;
        end else if (mode_reg == fbwm_pkg::MODE_SUBSEQUENCE) begin
            matched_next = progress_next >= len_used;
        end else begin
            matched_next = found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= fbwm_pkg::LEN_RESET;
            mode_reg  <= fbwm_pkg::MODE_CONTIGUOUS;
            codes_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fbwm_pkg::REG_PATTERN_LENGTH: len_reg   <= cfg_data[fbwm_pkg::LEN_W-1:0];
                fbwm_pkg::REG_MATCH_MODE:     mode_reg  <= cfg_data[0];
                fbwm_pkg::REG_PATTERN_CODES:  codes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= '0;
            found_reg    <= 1'b0;
        end else if (s_fire) begin
            progress_reg <= s_last_bundle ? '0 : progress_next;
            found_reg    <= s_last_bundle ? 1'b0 : found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_fire) begin
            m_matched_reg <= matched_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    // word state is gone after its last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_fire |=> (progress_reg == '0) && !found_reg && (hit_vec == '0))
        else $error("match state not cleared after last beat");

    // cursor never runs past the longest usable pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        progress_reg <= fbwm_pkg::LEN_W'(MAX_LEN))
        else $error("subsequence progress out of range");

    // a contiguous hit is sticky within the word
    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg && !last_fire |=> found_reg)
        else $error("found flag dropped mid-word");

    // results appear only after a last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(last_fire))
        else $error("result without a closing beat");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted over a stalled result");

endmodule

// ===== bench/feature_bundle_wildcard_matcher_tb.sv =====
module feature_bundle_wildcard_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FEAT    = fbwm_pkg::FEATURES_DEF;
    localparam int MAX_PAT = fbwm_pkg::MAX_PATTERN_DEF;

    // Tracks both match trackers for the words fed in and holds the match
    // bits still owed by the block.
    class match_scoreboard;
        logic [fbwm_pkg::LEN_W-1:0]   pat_len;
        logic                         mode;
        logic [fbwm_pkg::CODES_W-1:0] pat_codes;
        logic [MAX_PAT-1:0]           prefix_run;
        logic [fbwm_pkg::LEN_W-1:0]   gapped_pos;
        logic                         seen_run;
        logic                         want_q[$];
        int unsigned                  errors;
        int unsigned                  results;
        int unsigned                  hits;

        function new();
            pat_len    = fbwm_pkg::LEN_RESET;
            mode       = fbwm_pkg::MODE_CONTIGUOUS;
            pat_codes  = '0;
            prefix_run = '0;
            gapped_pos = '0;
            seen_run   = 1'b0;
            errors     = 0;
            results    = 0;
            hits       = 0;
        endfunction

        function void write_reg(logic [fbwm_pkg::CFG_IDX_W-1:0] idx,
                                logic [fbwm_pkg::CODES_W-1:0] data);
            case (idx)
                fbwm_pkg::REG_PATTERN_LENGTH: pat_len = data[fbwm_pkg::LEN_W-1:0];
                fbwm_pkg::REG_MATCH_MODE: mode = data[0];
                fbwm_pkg::REG_PATTERN_CODES: pat_codes = data;
                default: ;
            endcase
        endfunction

        function int used_len();
            return (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
        endfunction

        function bit bundle_fits(int p, logic [fbwm_pkg::WORD_W-1:0] w);
            logic [fbwm_pkg::CODE_W-1:0] pc;
            for (int j = 0; j < FEAT; j++) begin
                pc = pat_codes[2*(p*FEAT+j) +: 2];
                if (pc != fbwm_pkg::CODE_WILDCARD && pc != w[2*j +: 2])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_beat(logic [fbwm_pkg::WORD_W-1:0] w, logic last);
            int eff;
            logic [MAX_PAT-1:0] nxt;
            logic hit;
            eff = used_len();
            nxt = '0;
            for (int i = 0; i < MAX_PAT; i++) begin
                if (i < eff && (i == 0 || prefix_run[i-1]) && bundle_fits(i, w))
                    nxt[i] = 1'b1;
            end
            prefix_run = nxt;
            if (eff > 0 && prefix_run[eff-1])
                seen_run = 1'b1;
            if (gapped_pos < eff && bundle_fits(int'(gapped_pos), w))
                gapped_pos = gapped_pos + 1'b1;
            if (last) begin
                if (eff == 0)
                    hit = 1'b0;
                else if (mode == fbwm_pkg::MODE_SUBSEQUENCE)
                    hit = (gapped_pos >= eff);
                else
                    hit = seen_run;
                want_q = {want_q, hit};
                prefix_run = '0;
                gapped_pos = '0;
                seen_run   = 1'b0;
            end
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(logic got);
            logic want;
            if (want_q.size() == 0) begin
                flag($sformatf("matched=%b arrived with no word pending", got));
                return;
            end
            want = want_q.pop_front();
            results++;
            if (got !== want)
                flag($sformatf("word %0d: matched expected %b actual %b", results, want, got));
            if (got === 1'b1)
                hits++;
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [fbwm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fbwm_pkg::CODES_W-1:0]   cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [fbwm_pkg::WORD_W-1:0]    s_word_bundle;
    logic                           s_last_bundle;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_matched;

    match_scoreboard             sb;
    logic [fbwm_pkg::WORD_W-1:0] word_q[$];
    int unsigned                 beats_sent;
    int unsigned                 phases;
    bit                          no_gaps;
    bit                          squeeze_done;

    feature_bundle_wildcard_matcher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word_bundle (s_word_bundle),
        .s_last_bundle (s_last_bundle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_matched     (m_matched)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2ms;
        $display("feature_bundle_wildcard_matcher_tb failed");
        $finish;
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_matched);
    end

    initial begin
        int run;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!squeeze_done && sb.results >= 100) begin
                // long hold so the block backs up into the input side
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                squeeze_done = 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 8);
                repeat (run) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                run = pick_gap() + 1;
                repeat (run) @(posedge aclk);
            end
        end
    end

    task automatic write_cfg(input logic [fbwm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbwm_pkg::CODES_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // upper bits of the narrow registers carry junk to check the masking
    task automatic load_config(input logic [fbwm_pkg::LEN_W-1:0] len, input logic mode,
                               input logic [fbwm_pkg::CODES_W-1:0] codes);
        logic [fbwm_pkg::CODES_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_cfg(fbwm_pkg::REG_PATTERN_LENGTH,
                  {junk[fbwm_pkg::CODES_W-1:fbwm_pkg::LEN_W], len});
        junk = {$urandom, $urandom};
        write_cfg(fbwm_pkg::REG_MATCH_MODE, {junk[fbwm_pkg::CODES_W-1:1], mode});
        write_cfg(fbwm_pkg::REG_PATTERN_CODES, codes);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(input logic [fbwm_pkg::WORD_W-1:0] w, input logic last);
        int gap;
        s_valid       <= 1'b1;
        s_word_bundle <= w;
        s_last_bundle <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(w, last);
        beats_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_word();
        foreach (word_q[k])
            send_beat(word_q[k], k == word_q.size() - 1);
    endtask

    // wait out every owed result, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic logic [fbwm_pkg::WORD_W-1:0] fitting_bundle(int p);
        logic [fbwm_pkg::WORD_W-1:0] w;
        logic [fbwm_pkg::CODE_W-1:0] pc;
        for (int j = 0; j < FEAT; j++) begin
            pc = sb.pat_codes[2*(p*FEAT+j) +: 2];
            w[2*j +: 2] = (pc == fbwm_pkg::CODE_WILDCARD) ?
                          fbwm_pkg::CODE_W'($urandom_range(0, 3)) : pc;
        end
        return w;
    endfunction

    // mostly words carrying the pattern (adjacent or spread out), some broken
    // copies, the rest plain noise
    task automatic build_word();
        int eff, kind, n, p, j, tries;
        int at[MAX_PAT];
        bit spread;
        logic [fbwm_pkg::CODE_W-1:0] pc;
        eff  = sb.used_len();
        kind = $urandom_range(0, 9);
        word_q.delete();
        if (kind < 2 || eff == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            repeat (n) word_q = {word_q, fbwm_pkg::WORD_W'($urandom_range(0, 65535))};
        end else begin
            spread = (sb.mode == fbwm_pkg::MODE_SUBSEQUENCE) ? ($urandom_range(0, 3) != 0)
                                                             : ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 3))
                word_q = {word_q, fbwm_pkg::WORD_W'($urandom_range(0, 65535))};
            for (p = 0; p < eff; p++) begin
                if (spread && p > 0)
                    repeat ($urandom_range(0, 2))
                        word_q = {word_q, fbwm_pkg::WORD_W'($urandom_range(0, 65535))};
                at[p] = word_q.size();
                word_q = {word_q, fitting_bundle(p)};
            end
            repeat ($urandom_range(0, 3))
                word_q = {word_q, fbwm_pkg::WORD_W'($urandom_range(0, 65535))};
            if (kind >= 8) begin
                p = $urandom_range(0, eff - 1);
                for (tries = 0; tries < 16; tries++) begin
                    j  = $urandom_range(0, FEAT - 1);
                    pc = sb.pat_codes[2*(p*FEAT+j) +: 2];
                    if (pc != fbwm_pkg::CODE_WILDCARD) begin
                        word_q[at[p]][2*j +: 2] = pc + fbwm_pkg::CODE_W'($urandom_range(1, 3));
                        break;
                    end
                end
            end
        end
    endtask

    task automatic random_config();
        int r;
        logic [fbwm_pkg::LEN_W-1:0] len;
        logic [fbwm_pkg::CODES_W-1:0] codes;
        r = $urandom_range(0, 9);
        if (r < 7) len = fbwm_pkg::LEN_W'($urandom_range(1, 4));
        else if (r == 7) len = '0;
        else len = fbwm_pkg::LEN_W'($urandom_range(5, 7));
        case ($urandom_range(0, 5))
            0: codes = '0;
            1: codes = '1;
            2: codes = {$urandom, $urandom};
            default: begin
                for (int f = 0; f < fbwm_pkg::CODES_W / 2; f++)
                    codes[2*f +: 2] = ($urandom_range(0, 9) < 6) ?
                                      fbwm_pkg::CODE_WILDCARD :
                                      fbwm_pkg::CODE_W'($urandom_range(0, 3));
            end
        endcase
        load_config(len, logic'($urandom_range(0, 1)), codes);
    endtask

    initial begin
        sb            = new();
        beats_sent    = 0;
        phases        = 0;
        no_gaps       = 1'b0;
        squeeze_done  = 1'b0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_word_bundle = '0;
        s_last_bundle = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: one all-zero bundle, contiguous
        word_q = '{16'h0000};
        send_word();
        word_q = '{16'hFFFF};
        send_word();
        drain();

        // zero bundle then full wildcard; short word, star against wildcard
        load_config(3'd2, fbwm_pkg::MODE_CONTIGUOUS, {32'h0, 16'hFFFF, 16'h0000});
        word_q = '{16'h0000, 16'h1234};
        send_word();
        word_q = '{16'h0000};
        send_word();
        word_q = '{16'hAAAA, 16'h0000, 16'hFFFF};
        send_word();
        drain();

        // gapped, star in the word fails a non-wildcard feature
        load_config(3'd4, fbwm_pkg::MODE_SUBSEQUENCE,
                    {16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFC});
        word_q = '{16'h0000, 16'hFFFF, 16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF};
        send_word();
        drain();

        // empty pattern never matches
        load_config(3'd0, fbwm_pkg::MODE_CONTIGUOUS, '1);
        word_q = '{16'hFFFF};
        send_word();
        drain();

        // oversized lengths saturate to the largest pattern
        load_config(3'd7, fbwm_pkg::MODE_CONTIGUOUS, '1);
        word_q = '{16'h1111, 16'h2222, 16'h3333, 16'h4444};
        send_word();
        drain();
        load_config(3'd5, fbwm_pkg::MODE_SUBSEQUENCE, '1);
        word_q = '{16'h0009, 16'h0008, 16'h0007, 16'h0006};
        send_word();
        drain();

        while (beats_sent < 1900) begin
            random_config();
            phases++;
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 25)) begin
                build_word();
                send_word();
            end
            drain();
        end
        no_gaps = 1'b0;
        drain();
        repeat (5) @(posedge aclk);

        $display("%0d bundles over %0d random configurations; %0d words checked, %0d matched",
                 beats_sent, phases, sb.results, sb.hits);
        $display("%0d mismatches, %0d results still owed", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("feature_bundle_wildcard_matcher_tb passed");
        else
            $display("feature_bundle_wildcard_matcher_tb failed");
        $finish;
    end
endmodule
